@@ rtl/plst_pkg.sv @@
package plst_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned VAL_W    = 32;

  typedef enum logic [2:0] {
    MODE_APPEND = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_DELETE = 3'd2,
    MODE_READ   = 3'd3,
    MODE_FIND   = 3'd4,
    MODE_CLEAR  = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_RANGE    = 3'd1,
    STATUS_EMPTY    = 3'd2,
    STATUS_FULL     = 3'd3,
    STATUS_NOTFOUND = 3'd4
  } status_e;

  typedef struct packed {
    mode_e                    mode;
    logic [7:0]               position;
    logic signed [VAL_W-1:0]  item_value;
  } cmd_t;

  typedef struct packed {
    status_e                  status;
    logic signed [VAL_W-1:0]  result_value;
    logic [7:0]               found_position;
    logic [CNT_W-1:0]         list_length;
  } rsp_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic [IDX_W-1:0]         pidx;
    logic [CNT_W-1:0]         count;
    logic signed [VAL_W-1:0]  key;
  } cell_ctrl_t;

  typedef struct packed {
    logic                     hit;
    logic signed [VAL_W-1:0]  rd_data;
  } cell_stat_t;

endpackage

@@ rtl/positional_list_store_core.sv @@
// A command taken at an edge with start high and busy low is registered in cmd_q and
// executed while exec_q is high; its result is registered in rsp_q and shown with done_o.
// A new command is not taken while busy is high; busy is high for the single execute
// cycle in which the row of cells shifts and compares in parallel.
// Reset clears the list length and all control state; stored values are not cleared.
module positional_list_store_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  plst_pkg::cmd_t     cmd_i,
  output logic               done_o,
  output plst_pkg::rsp_t     rsp_o
);

  logic                          exec_q;
  plst_pkg::cmd_t                cmd_q;
  logic [plst_pkg::CNT_W-1:0]    count_q, count_d;
  plst_pkg::rsp_t                rsp_q, rsp_d;
  logic                          done_q;

  plst_pkg::cell_ctrl_t          ctrl;
  plst_pkg::cell_stat_t          stat [plst_pkg::CAPACITY];
  logic signed [plst_pkg::VAL_W-1:0] vals [plst_pkg::CAPACITY];

  logic                          found;
  logic [plst_pkg::IDX_W-1:0]    first;
  logic signed [plst_pkg::VAL_W-1:0] rd_val;

  logic [plst_pkg::CNT_W:0]      pos_w, cnt_w;

  assign busy = exec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      exec_q <= start && !exec_q;
      done_q <= exec_q;
      if (exec_q) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !exec_q) begin
      cmd_q <= cmd_i;
    end
    if (exec_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign pos_w = {1'b0, cmd_q.position};
  assign cnt_w = {1'b0, count_q};

  always_comb begin
    ctrl.ins   = 1'b0;
    ctrl.del   = 1'b0;
    ctrl.pidx  = plst_pkg::IDX_W'(cmd_q.position - 8'd1);
    ctrl.count = count_q;
    ctrl.key   = cmd_q.item_value;
    count_d    = count_q;
    rsp_d.status         = plst_pkg::STATUS_OK;
    rsp_d.result_value   = '0;
    rsp_d.found_position = '0;
    unique case (cmd_q.mode)
      plst_pkg::MODE_APPEND: begin
        if (count_q >= plst_pkg::CNT_W'(plst_pkg::CAPACITY)) begin
          rsp_d.status = plst_pkg::STATUS_FULL;
        end else begin
          ctrl.ins  = exec_q;
          ctrl.pidx = count_q[plst_pkg::IDX_W-1:0];
          count_d   = count_q + 1'b1;
        end
      end
      plst_pkg::MODE_INSERT: begin
        if (count_q == '0) begin
          rsp_d.status = plst_pkg::STATUS_EMPTY;
        end else if ((cmd_q.position == '0) || (pos_w > cnt_w + 1'b1)) begin
          rsp_d.status = plst_pkg::STATUS_RANGE;
        end else if (count_q >= plst_pkg::CNT_W'(plst_pkg::CAPACITY)) begin
          rsp_d.status = plst_pkg::STATUS_FULL;
        end else begin
          ctrl.ins = exec_q;
          count_d  = count_q + 1'b1;
        end
      end
      plst_pkg::MODE_DELETE: begin
        if (count_q == '0) begin
          rsp_d.status = plst_pkg::STATUS_EMPTY;
        end else if ((cmd_q.position == '0) || (cmd_q.position > count_q)) begin
          rsp_d.status = plst_pkg::STATUS_RANGE;
        end else begin
          rsp_d.result_value = rd_val;
          ctrl.del = exec_q;
          count_d  = count_q - 1'b1;
        end
      end
      plst_pkg::MODE_READ: begin
        if (count_q == '0) begin
          rsp_d.status = plst_pkg::STATUS_EMPTY;
        end else if ((cmd_q.position == '0) || (cmd_q.position > count_q)) begin
          rsp_d.status = plst_pkg::STATUS_RANGE;
        end else begin
          rsp_d.result_value = rd_val;
        end
      end
      plst_pkg::MODE_FIND: begin
        if (count_q == '0) begin
          rsp_d.status = plst_pkg::STATUS_EMPTY;
        end else if (!found) begin
          rsp_d.status = plst_pkg::STATUS_NOTFOUND;
        end else begin
          rsp_d.found_position = 8'(first) + 8'd1;
        end
      end
      plst_pkg::MODE_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
    rsp_d.list_length = count_d;
  end

  for (genvar k = 0; k < plst_pkg::CAPACITY; k++) begin : g_cell
    logic signed [plst_pkg::VAL_W-1:0] left, right;
    if (k == 0) begin : g_first
      assign left = cmd_q.item_value;
    end else begin : g_mid_l
      assign left = vals[k-1];
    end
    if (k == plst_pkg::CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = vals[k+1];
    end
    plst_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (plst_pkg::IDX_W'(k)),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .val_o   (vals[k]),
      .stat_o  (stat[k])
    );
  end

  plst_sel u_sel (
    .stat_i  (stat),
    .found_o (found),
    .first_o (first),
    .rd_o    (rd_val)
  );

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

@@ rtl/plst_cell.sv @@
module plst_cell (
  input  logic                            clk_i,
  input  logic [plst_pkg::IDX_W-1:0]      idx_i,
  input  plst_pkg::cell_ctrl_t            ctrl_i,
  input  logic signed [plst_pkg::VAL_W-1:0] left_i,
  input  logic signed [plst_pkg::VAL_W-1:0] right_i,
  output logic signed [plst_pkg::VAL_W-1:0] val_o,
  output plst_pkg::cell_stat_t            stat_o
);

  logic signed [plst_pkg::VAL_W-1:0] val_q;
  logic signed [plst_pkg::VAL_W-1:0] val_d;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins && (idx_i == ctrl_i.pidx)) begin
      val_d = ctrl_i.key;
    end else if (ctrl_i.ins && (idx_i > ctrl_i.pidx)) begin
      val_d = left_i;
    end else if (ctrl_i.del && (idx_i >= ctrl_i.pidx)) begin
      val_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o          = val_q;
  assign stat_o.hit     = (plst_pkg::CNT_W'(idx_i) < ctrl_i.count) && (val_q == ctrl_i.key);
  assign stat_o.rd_data = (idx_i == ctrl_i.pidx) ? val_q : '0;

endmodule

@@ rtl/plst_sel.sv @@
module plst_sel (
  input  plst_pkg::cell_stat_t             stat_i [plst_pkg::CAPACITY],
  output logic                             found_o,
  output logic [plst_pkg::IDX_W-1:0]       first_o,
  output logic signed [plst_pkg::VAL_W-1:0] rd_o
);

  always_comb begin
    found_o = 1'b0;
    first_o = '0;
    rd_o    = '0;
    for (int k = plst_pkg::CAPACITY - 1; k >= 0; k--) begin
      if (stat_i[k].hit) begin
        found_o = 1'b1;
        first_o = plst_pkg::IDX_W'(k);
      end
      rd_o = rd_o | stat_i[k].rd_data;
    end
  end

endmodule

@@ rtl/plst_checker.sv @@
module plst_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input plst_pkg::rsp_t rsp_o
);

  // Every accepted transaction occupies exactly one execute cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy ##1 !busy)
    else $error("execute cycle did not follow an accepted transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o)
    else $error("result missing after execute cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy))
    else $error("result strobe without a preceding execute cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.list_length <= 8'(plst_pkg::CAPACITY))
    else $error("list length beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status != plst_pkg::STATUS_OK) |-> rsp_o.found_position == '0)
    else $error("position reported on a failed transaction");

endmodule

bind positional_list_store_core plst_checker u_plst_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

@@ test/tb_positional_list_store_core.sv @@
module tb_positional_list_store_core;
  import plst_pkg::*;

  localparam int unsigned EFFECTIVE_ITEMS = 875;
  localparam int unsigned LIMIT_CYCLES    = 100000;
  localparam int unsigned DRAIN_CYCLES    = 8;

  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  localparam int unsigned PH_FILL   = 0;
  localparam int unsigned PH_GROW   = 1;
  localparam int unsigned PH_SHRINK = 2;
  localparam int unsigned PH_ACCESS = 3;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  cmd_t cmd_i  = '0;
  logic done_o;
  rsp_t rsp_o;

  cmd_t                    cmd_queue[$];
  rsp_t                    expected_rsp_q[$];
  logic signed [VAL_W-1:0] list_image[$];

  int unsigned gen_len;
  int unsigned n_effective;
  int unsigned n_generated;
  int unsigned n_accepted;
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned peak_len;
  int unsigned cycle_cnt;
  int unsigned idle_left;
  int unsigned calm_left;
  int unsigned status_seen[5];

  positional_list_store_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // Works out the response to one command and updates the list image.
  function automatic void predict_list_response(input cmd_t c);
    rsp_t        r;
    int unsigned n;
    int unsigned p;
    bit          hit;
    r = '0;
    r.status = STATUS_OK;
    n = list_image.size();
    p = c.position;
    hit = 1'b0;
    case (c.mode)
      MODE_APPEND: begin
        if (n >= CAPACITY) r.status = STATUS_FULL;
        else list_image.push_back(c.item_value);
      end
      MODE_INSERT: begin
        if (n == 0) r.status = STATUS_EMPTY;
        else if (p < 1 || p > n + 1) r.status = STATUS_RANGE;
        else if (n >= CAPACITY) r.status = STATUS_FULL;
        else list_image.insert(p - 1, c.item_value);
      end
      MODE_DELETE: begin
        if (n == 0) r.status = STATUS_EMPTY;
        else if (p < 1 || p > n) r.status = STATUS_RANGE;
        else begin
          r.result_value = list_image[p - 1];
          list_image.delete(p - 1);
        end
      end
      MODE_READ: begin
        if (n == 0) r.status = STATUS_EMPTY;
        else if (p < 1 || p > n) r.status = STATUS_RANGE;
        else r.result_value = list_image[p - 1];
      end
      MODE_FIND: begin
        if (n == 0) r.status = STATUS_EMPTY;
        else begin
          r.status = STATUS_NOTFOUND;
          for (int unsigned k = 0; k < n; k++) begin
            if (!hit && list_image[k] == c.item_value) begin
              hit = 1'b1;
              r.status = STATUS_OK;
              r.found_position = 8'(k + 1);
            end
          end
        end
      end
      MODE_CLEAR: list_image.delete();
      default: ;
    endcase
    r.list_length = CNT_W'(list_image.size());
    if (list_image.size() > peak_len) peak_len = list_image.size();
    expected_rsp_q.push_back(r);
  endfunction

  function automatic void push_cmd(input logic [2:0] m, input int unsigned p,
                                   input logic signed [VAL_W-1:0] v);
    cmd_t c;
    c.mode = mode_e'(m);
    c.position = 8'(p);
    c.item_value = v;
    cmd_queue.push_back(c);
    n_generated++;
    if (m <= MODE_CLEAR) n_effective++;
    case (m)
      MODE_APPEND: if (gen_len < CAPACITY) gen_len++;
      MODE_INSERT: begin
        if (gen_len > 0 && p >= 1 && p <= gen_len + 1 && gen_len < CAPACITY) gen_len++;
      end
      MODE_DELETE: if (gen_len > 0 && p >= 1 && p <= gen_len) gen_len--;
      MODE_CLEAR: gen_len = 0;
      default: ;
    endcase
  endfunction

  // A small pool of values makes finds hit often and produces duplicates.
  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] pool[8];
    pool = '{32'sh0000_0000, -32'sd1, 32'sh7fff_ffff, 32'sh8000_0000,
             32'sd1, 32'sd42, 32'sh5a5a_5a5a, 32'sha5a5_a5a5};
    if ($urandom_range(0, 1) == 0) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic int unsigned pick_position(input int unsigned valid_max);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return (valid_max == 0) ? 1 : $urandom_range(1, valid_max);
    if (r < 90) return 0;
    if (r < 95) return valid_max + 1;
    return $urandom_range(0, 255);
  endfunction

  function automatic void push_noise();
    logic [2:0] m;
    m = 3'($urandom_range(0, 7));
    push_cmd(m, $urandom_range(0, 255), $urandom);
  endfunction

  initial begin
    int unsigned phase;
    int unsigned phase_len;
    int unsigned r;

    push_cmd(MODE_FIND,   1, 32'sd7);
    push_cmd(MODE_READ,   1, 32'sd0);
    push_cmd(MODE_DELETE, 1, 32'sd0);
    push_cmd(MODE_INSERT, 1, 32'sd5);
    push_cmd(MODE_APPEND, 0, 32'sh7fff_ffff);
    push_cmd(MODE_APPEND, 255, 32'sh8000_0000);
    push_cmd(MODE_INSERT, 1, -32'sd1);
    push_cmd(MODE_INSERT, 4, 32'sh5a5a_5a5a);
    push_cmd(MODE_INSERT, 0, 32'sd9);
    push_cmd(MODE_INSERT, 6, 32'sd9);
    push_cmd(MODE_READ,   0, 32'sd0);
    push_cmd(MODE_READ,   5, 32'sd0);
    push_cmd(MODE_READ,   255, 32'sd0);
    push_cmd(MODE_READ,   4, 32'sd0);
    push_cmd(MODE_FIND,   0, 32'sh8000_0000);
    push_cmd(MODE_FIND,   0, 32'sd12345);
    push_cmd(MODE_DELETE, 5, 32'sd0);
    push_cmd(MODE_DELETE, 1, 32'sd0);
    push_cmd(MODE_DELETE, 3, 32'sd0);
    push_cmd(MODE_SPARE_LO, 2, 32'sd3);
    push_cmd(MODE_SPARE_HI, 255, -32'sd1);
    push_cmd(MODE_CLEAR,  0, 32'sd0);
    push_cmd(MODE_APPEND, 0, 32'sd1);
    push_cmd(MODE_DELETE, 1, 32'sd0);

    phase = PH_FILL;
    while (n_effective < EFFECTIVE_ITEMS) begin
      if ($urandom_range(0, 9) == 0) push_cmd(MODE_CLEAR, $urandom_range(0, 255), $urandom);
      if (phase == PH_FILL) begin
        while (gen_len < CAPACITY) push_cmd(MODE_APPEND, $urandom_range(0, 255), pick_value());
        push_cmd(MODE_APPEND, 0, pick_value());
        push_cmd(MODE_INSERT, $urandom_range(1, CAPACITY + 1), pick_value());
        push_cmd(MODE_INSERT, CAPACITY + 2, pick_value());
        push_cmd(MODE_READ, CAPACITY, 32'sd0);
        push_cmd(MODE_FIND, 0, pick_value());
      end else begin
        phase_len = $urandom_range(8, 60);
        repeat (phase_len) begin
          r = $urandom_range(0, 99);
          case (phase)
            PH_GROW: begin
              if (r < 55) push_cmd(MODE_APPEND, $urandom_range(0, 255), pick_value());
              else if (r < 85) push_cmd(MODE_INSERT, pick_position(gen_len + 1), pick_value());
              else if (r < 92) push_cmd(MODE_READ, pick_position(gen_len), pick_value());
              else if (r < 97) push_cmd(MODE_FIND, $urandom_range(0, 255), pick_value());
              else push_noise();
            end
            PH_SHRINK: begin
              if (r < 65) push_cmd(MODE_DELETE, pick_position(gen_len), pick_value());
              else if (r < 80) push_cmd(MODE_READ, pick_position(gen_len), pick_value());
              else if (r < 90) push_cmd(MODE_FIND, $urandom_range(0, 255), pick_value());
              else if (r < 95) push_cmd(MODE_APPEND, $urandom_range(0, 255), pick_value());
              else push_noise();
            end
            default: begin
              if (r < 40) push_cmd(MODE_READ, pick_position(gen_len), pick_value());
              else if (r < 75) push_cmd(MODE_FIND, $urandom_range(0, 255), pick_value());
              else if (r < 85) push_cmd(MODE_APPEND, $urandom_range(0, 255), pick_value());
              else if (r < 95) push_cmd(MODE_INSERT, pick_position(gen_len + 1), pick_value());
              else push_noise();
            end
          endcase
        end
      end
      r = $urandom_range(0, 9);
      if (r == 0) phase = PH_FILL;
      else if (r < 4) phase = PH_GROW;
      else if (r < 7) phase = PH_SHRINK;
      else phase = PH_ACCESS;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_generated || expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d commands, %0d responses checked, peak list length %0d of %0d.",
             n_accepted, n_checked, peak_len, CAPACITY);
    $display("Statuses seen: ok %0d, range %0d, empty %0d, full %0d, not found %0d.",
             status_seen[STATUS_OK], status_seen[STATUS_RANGE], status_seen[STATUS_EMPTY],
             status_seen[STATUS_FULL], status_seen[STATUS_NOTFOUND]);
    if (n_errors == 0) begin
      $display("** positional_list_store_core: PASSED **");
    end else begin
      $display("** positional_list_store_core: FAILED **");
    end
    $finish;
  end

  // Driver: a transaction is accepted at an edge with start high and busy low.
  always @(posedge clk_i) begin
    if (rst_ni && !(start && busy)) begin
      if (start) begin
        predict_list_response(cmd_i);
        n_accepted++;
        if (calm_left > 0) begin
          calm_left--;
          idle_left = 0;
        end else if ($urandom_range(0, 15) == 0) begin
          calm_left = $urandom_range(10, 40);
          idle_left = 0;
        end else begin
          idle_left = $urandom_range(0, 12);
        end
      end
      if (idle_left > 0 || cmd_queue.size() == 0) begin
        if (idle_left > 0) idle_left--;
        start <= 1'b0;
      end else begin
        cmd_i <= cmd_queue.pop_front();
        start <= 1'b1;
      end
    end
  end

  // Monitor: every strobed response is checked against the oldest prediction.
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && done_o) begin
      if (expected_rsp_q.size() == 0) begin
        $error("Response seen with no transaction outstanding.");
        n_errors++;
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        n_checked++;
        if (exp_rsp.status <= STATUS_NOTFOUND) status_seen[exp_rsp.status]++;
        if (rsp_o.status !== exp_rsp.status) begin
          $error("status: expected %0d, got %0d", exp_rsp.status, rsp_o.status);
          n_errors++;
        end
        if (rsp_o.result_value !== exp_rsp.result_value) begin
          $error("result_value: expected %0d, got %0d",
                 exp_rsp.result_value, rsp_o.result_value);
          n_errors++;
        end
        if (rsp_o.found_position !== exp_rsp.found_position) begin
          $error("found_position: expected %0d, got %0d",
                 exp_rsp.found_position, rsp_o.found_position);
          n_errors++;
        end
        if (rsp_o.list_length !== exp_rsp.list_length) begin
          $error("list_length: expected %0d, got %0d",
                 exp_rsp.list_length, rsp_o.list_length);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d of %0d commands taken.",
               cycle_cnt, n_accepted, n_generated);
      $display("** positional_list_store_core: FAILED **");
      $finish;
    end
  end

endmodule
